// ===== design/lbmc_pkg.sv =====
// shared types, constants and the arctangent table for the beam motion compensation unit
// used by every module of the design; depends on nothing
package lbmc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TAB_LEN      = 24;
   localparam int NSTEPS       = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   localparam int STEP_W       = 5;
   localparam int DW           = 48;
   localparam int PW           = 56;
   localparam int RANGE_W      = 24;
   localparam int ANGLE_W      = 16;
   localparam int POS_W        = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int LATENCY      = 2 * NSTEPS + 6;

   localparam logic signed [23:0] KINV_S = 24'sd2547003;
   localparam logic [21:0]        KINV_U = 22'd2547003;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_POS_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_POS_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HEADING = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic                 inf;
      logic [RANGE_W-1:0]   beam_range;
      logic [ANGLE_W-1:0]   beam_angle;
   } ctl_type;

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic [31:0]          z;
   } vec_type;

   function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/lbmc_rot_stage.sv =====
// one registered rotation-mode cordic step, applied to two vectors side by side
// depends on lbmc_pkg
module lbmc_rot_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lbmc_pkg::STEP_W-1:0] step,
   input  lbmc_pkg::ctl_type           ctl_in,
   input  lbmc_pkg::vec_type           p_in,
   input  lbmc_pkg::vec_type           q_in,
   output lbmc_pkg::ctl_type           ctl_out,
   output lbmc_pkg::vec_type           p_out,
   output lbmc_pkg::vec_type           q_out
);
   import lbmc_pkg::*;

   ctl_type ctl_ff;
   vec_type p_ff, p_in_next, q_ff, q_in_next;

   function automatic vec_type rot(input vec_type v, input logic [STEP_W-1:0] i);
      vec_type o;
      logic signed [DW-1:0] tx, ty;
      tx = v.x >>> i;
      ty = v.y >>> i;
      if (!v.z[31]) begin
         o.x = v.x - ty;
         o.y = v.y + tx;
         o.z = v.z - atan_val(i);
      end else begin
         o.x = v.x + ty;
         o.y = v.y - tx;
         o.z = v.z + atan_val(i);
      end
      return o;
   endfunction

   always_comb begin
      p_in_next = rot(p_in, step);
      q_in_next = rot(q_in, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
      p_ff <= p_in_next;
      q_ff <= q_in_next;
   end

   assign ctl_out = ctl_ff;
   assign p_out   = p_ff;
   assign q_out   = q_ff;
endmodule

// ===== design/lbmc_vec_stage.sv =====
// one registered vectoring-mode cordic step
// depends on lbmc_pkg
module lbmc_vec_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lbmc_pkg::STEP_W-1:0] step,
   input  lbmc_pkg::ctl_type           ctl_in,
   input  lbmc_pkg::vec_type           v_in,
   output lbmc_pkg::ctl_type           ctl_out,
   output lbmc_pkg::vec_type           v_out
);
   import lbmc_pkg::*;

   ctl_type ctl_ff;
   vec_type v_ff, v_in_next;
   logic signed [DW-1:0] tx, ty;

   always_comb begin
      tx = v_in.x >>> step;
      ty = v_in.y >>> step;
      // y strictly positive rotates clockwise
      if (!v_in.y[DW-1] && (v_in.y != '0)) begin
         v_in_next.x = v_in.x + ty;
         v_in_next.y = v_in.y - tx;
         v_in_next.z = v_in.z + atan_val(step);
      end else begin
         v_in_next.x = v_in.x - ty;
         v_in_next.y = v_in.y + tx;
         v_in_next.z = v_in.z - atan_val(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
      v_ff <= v_in_next;
   end

   assign ctl_out = ctl_ff;
   assign v_out   = v_ff;
endmodule

// ===== design/lidar_beam_motion_compensation_unit.sv =====
// top level of the lidar beam motion compensation unit: csr file and full pipeline
// depends on lbmc_pkg, lbmc_rot_stage and lbmc_vec_stage
//
// Takes one beam transaction per clock: a beam is accepted whenever start is high and
// busy is low, and busy is only high during reset. Every beam leaves on the rsp_ ports
// one cycle wide and marked by rsp_valid, in arrival order; the receiver cannot stall,
// so nothing is ever held back. The pipeline consists of the two chains of unrolled cordic
// stages (one rotation chain that turns the beam and the pose offset in parallel, then one
// vectoring chain), plus six stages for capture, the gain multiplies, rounding, summing
// and the final range scaling. The reference pose csr registers are read live by the first
// stage and must only be changed while no beam is in flight.
module lidar_beam_motion_compensation_unit (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [lbmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_write_data,
   // beam in
   input  logic                           start,
   output logic                           busy,
   input  logic [23:0]                    req_beam_range,
   input  logic signed [15:0]             req_beam_angle,
   input  logic                           req_range_infinite,
   input  logic signed [31:0]             req_pose_x,
   input  logic signed [31:0]             req_pose_y,
   input  logic signed [15:0]             req_pose_heading,
   // corrected beam out
   output logic                           rsp_valid,
   output logic [23:0]                    rsp_fixed_range,
   output logic signed [15:0]             rsp_fixed_angle,
   output logic                           rsp_was_corrected
);
   import lbmc_pkg::*;

   // reference pose registers
   logic signed [31:0] ref_pos_x_ff, ref_pos_y_ff;
   logic [15:0]        ref_heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_pos_x_ff   <= '0;
         ref_pos_y_ff   <= '0;
         ref_heading_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_REF_POS_X:   ref_pos_x_ff   <= csr_write_data;
            CSR_REF_POS_Y:   ref_pos_y_ff   <= csr_write_data;
            CSR_REF_HEADING: ref_heading_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // stage a: capture, pose offset and merged rotation angles
   ctl_type            a_ctl_ff, a_ctl_in;
   logic signed [32:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic [15:0]        a_ang1_ff, a_ang1_in, a_ang2_ff, a_ang2_in;

   always_comb begin
      a_ctl_in.valid      = accept;
      a_ctl_in.inf        = req_range_infinite;
      a_ctl_in.beam_range = req_beam_range;
      a_ctl_in.beam_angle = req_beam_angle;
      a_dx_in   = 33'(req_pose_x) - 33'(ref_pos_x_ff);
      a_dy_in   = 33'(req_pose_y) - 33'(ref_pos_y_ff);
      // beam bearing plus beam-time yaw minus reference yaw, mod one turn
      a_ang1_in = req_beam_angle + req_pose_heading - ref_heading_ff;
      a_ang2_in = 16'd0 - ref_heading_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid <= 1'b0;
      end else begin
         a_ctl_ff <= a_ctl_in;
      end
      a_dx_ff   <= a_dx_in;
      a_dy_ff   <= a_dy_in;
      a_ang1_ff <= a_ang1_in;
      a_ang2_ff <= a_ang2_in;
   end

   // stage b: cordic gain pre-scaling multiplies
   ctl_type               b_ctl_ff;
   logic signed [PW-1:0]  b_pr_ff, b_pr_in, b_px_ff, b_px_in, b_py_ff, b_py_in;
   logic [15:0]           b_ang1_ff, b_ang2_ff;

   always_comb begin
      b_pr_in = $signed({1'b0, a_ctl_ff.beam_range}) * KINV_S;
      b_px_in = a_dx_ff * KINV_S;
      b_py_in = a_dy_ff * KINV_S;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.valid <= 1'b0;
      end else begin
         b_ctl_ff <= a_ctl_ff;
      end
      b_pr_ff   <= b_pr_in;
      b_px_ff   <= b_px_in;
      b_py_ff   <= b_py_in;
      b_ang1_ff <= a_ang1_ff;
      b_ang2_ff <= a_ang2_ff;
   end

   // stage c: round to guard bits and fold the angle into the right half plane
   function automatic logic signed [DW-1:0] round14(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = (v + PW'(8192)) >>> 14;
      return t[DW-1:0];
   endfunction

   function automatic vec_type fold(input logic signed [DW-1:0] x,
                                    input logic signed [DW-1:0] y,
                                    input logic [15:0] ang);
      vec_type     o;
      logic [31:0] z, zq;
      z  = {ang, 16'h0000};
      zq = z + 32'h4000_0000;
      if (zq[31]) begin
         o.x = -x;
         o.y = -y;
         o.z = z + 32'h8000_0000;
      end else begin
         o.x = x;
         o.y = y;
         o.z = z;
      end
      return o;
   endfunction

   ctl_type c_ctl_ff;
   vec_type c_p_ff, c_p_in, c_q_ff, c_q_in;

   always_comb begin
      c_p_in = fold(round14(b_pr_ff), '0, b_ang1_ff);
      c_q_in = fold(round14(b_px_ff), round14(b_py_ff), b_ang2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.valid <= 1'b0;
      end else begin
         c_ctl_ff <= b_ctl_ff;
      end
      c_p_ff <= c_p_in;
      c_q_ff <= c_q_in;
   end

   // rotation chain: beam and pose offset turned in lockstep
   ctl_type rot_ctl [NSTEPS+1];
   vec_type rot_p   [NSTEPS+1];
   vec_type rot_q   [NSTEPS+1];

   assign rot_ctl[0] = c_ctl_ff;
   assign rot_p[0]   = c_p_ff;
   assign rot_q[0]   = c_q_ff;

   for (genvar g = 0; g < NSTEPS; g++) begin : g_rot
      lbmc_rot_stage u_rot (
         .clock   (clock),
         .reset   (reset),
         .step    (STEP_W'(g)),
         .ctl_in  (rot_ctl[g]),
         .p_in    (rot_p[g]),
         .q_in    (rot_q[g]),
         .ctl_out (rot_ctl[g+1]),
         .p_out   (rot_p[g+1]),
         .q_out   (rot_q[g+1])
      );
   end

   // stage d: point in reference frame, folded for vectoring
   ctl_type              d_ctl_ff;
   vec_type              d_v_ff, d_v_in;
   logic signed [DW-1:0] d_sx, d_sy;

   always_comb begin
      d_sx = rot_p[NSTEPS].x + rot_q[NSTEPS].x;
      d_sy = rot_p[NSTEPS].y + rot_q[NSTEPS].y;
      if (d_sx[DW-1]) begin
         d_v_in.x = -d_sx;
         d_v_in.y = -d_sy;
         d_v_in.z = 32'h8000_0000;
      end else begin
         d_v_in.x = d_sx;
         d_v_in.y = d_sy;
         d_v_in.z = 32'h0000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff.valid <= 1'b0;
      end else begin
         d_ctl_ff <= rot_ctl[NSTEPS];
      end
      d_v_ff <= d_v_in;
   end

   // vectoring chain: magnitude and bearing
   ctl_type vec_ctl [NSTEPS+1];
   vec_type vec_v   [NSTEPS+1];

   assign vec_ctl[0] = d_ctl_ff;
   assign vec_v[0]   = d_v_ff;

   for (genvar g = 0; g < NSTEPS; g++) begin : g_vec
      lbmc_vec_stage u_vec (
         .clock   (clock),
         .reset   (reset),
         .step    (STEP_W'(g)),
         .ctl_in  (vec_ctl[g]),
         .v_in    (vec_v[g]),
         .ctl_out (vec_ctl[g+1]),
         .v_out   (vec_v[g+1])
      );
   end

   // stage e: gain removal as two 24x22 partial products
   ctl_type     e_ctl_ff;
   logic [45:0] e_lo_ff, e_lo_in, e_hi_ff, e_hi_in;
   logic [31:0] e_z_ff;

   always_comb begin
      e_lo_in = 46'(vec_v[NSTEPS].x[23:0]) * 46'(KINV_U);
      e_hi_in = 46'(vec_v[NSTEPS].x[47:24]) * 46'(KINV_U);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff.valid <= 1'b0;
      end else begin
         e_ctl_ff <= vec_ctl[NSTEPS];
      end
      e_lo_ff <= e_lo_in;
      e_hi_ff <= e_hi_in;
      e_z_ff  <= vec_v[NSTEPS].z;
   end

   // stage f: sum, round, saturate and pass-through select
   logic        f_valid_ff;
   logic [23:0] f_range_ff, f_range_in;
   logic [15:0] f_angle_ff, f_angle_in;
   logic        f_corr_ff;
   logic [71:0] f_sum;
   logic [31:0] f_zr;

   always_comb begin
      f_sum = {2'b00, e_hi_ff, 24'h0} + 72'(e_lo_ff) + 72'h2000_0000;
      f_zr  = e_z_ff + 32'h0000_8000;
      if (e_ctl_ff.inf) begin
         f_range_in = e_ctl_ff.beam_range;
         f_angle_in = e_ctl_ff.beam_angle;
      end else begin
         f_range_in = (|f_sum[71:54]) ? 24'hFF_FFFF : f_sum[53:30];
         f_angle_in = f_zr[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_ctl_ff.valid;
      end
      f_range_ff <= f_range_in;
      f_angle_ff <= f_angle_in;
      f_corr_ff  <= ~e_ctl_ff.inf;
   end

   assign rsp_valid         = f_valid_ff;
   assign rsp_fixed_range   = f_range_ff;
   assign rsp_fixed_angle   = f_angle_ff;
   assign rsp_was_corrected = f_corr_ff;
endmodule

// ===== design/lbmc_checker.sv =====
// port-level checks on the beam motion compensation unit, bound to the top level
// depends on lbmc_pkg and lidar_beam_motion_compensation_unit
module lbmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [23:0] req_beam_range,
   input logic [15:0] req_beam_angle,
   input logic        req_range_infinite,
   input logic        rsp_valid,
   input logic [23:0] rsp_fixed_range,
   input logic [15:0] rsp_fixed_angle,
   input logic        rsp_was_corrected
);
   import lbmc_pkg::*;

   // fixed latency: each accepted transaction yields exactly one result
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result strobe");

   // no strobe without an accepted transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result strobe without accepted transaction");

   a_corr_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_was_corrected == !$past(req_range_infinite, LATENCY)))
      else $error("corrected flag does not follow infinite flag");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_was_corrected) |->
         (rsp_fixed_range == $past(req_beam_range, LATENCY)) &&
         (rsp_fixed_angle == $past(req_beam_angle, LATENCY)))
      else $error("infinite beam not passed through unchanged");
endmodule

bind lidar_beam_motion_compensation_unit lbmc_checker u_lbmc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_beam_range     (req_beam_range),
   .req_beam_angle     (req_beam_angle),
   .req_range_infinite (req_range_infinite),
   .rsp_valid          (rsp_valid),
   .rsp_fixed_range    (rsp_fixed_range),
   .rsp_fixed_angle    (rsp_fixed_angle),
   .rsp_was_corrected  (rsp_was_corrected)
);

// ===== bench/tb.sv =====
// self-checking bench for lidar_beam_motion_compensation_unit: directed, csr and random beams
// depends on lbmc_pkg and the unit; carries its own bit-exact model of the correction math
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbmc_pkg::*;

   // csr index 3 decodes to nothing and must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam longint GAIN_INV = 2547003;
   localparam int     RAND_ITEMS = 2000;
   localparam int     QUIET_TAIL = 300;
   localparam longint ARCTAN_TAB [TAB_LEN] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

   typedef struct {
      logic [23:0] range;
      logic [15:0] angle;
      logic        corrected;
   } beam_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_write_data = '0;
   logic                 start = 1'b0;
   logic                 busy;
   logic [23:0]          req_beam_range = '0;
   logic signed [15:0]   req_beam_angle = '0;
   logic                 req_range_infinite = 1'b0;
   logic signed [31:0]   req_pose_x = '0;
   logic signed [31:0]   req_pose_y = '0;
   logic signed [15:0]   req_pose_heading = '0;
   logic                 rsp_valid;
   logic [23:0]          rsp_fixed_range;
   logic signed [15:0]   rsp_fixed_angle;
   logic                 rsp_was_corrected;

   // bench copy of the reference pose registers
   logic [31:0] ref_x_shadow = '0;
   logic [31:0] ref_y_shadow = '0;
   logic [15:0] ref_hdg_shadow = '0;

   beam_result_type pending_beams[$];
   int error_count = 0;

   lidar_beam_motion_compensation_unit uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // rotation cordic with the gain removed up front, 8 guard bits
   function automatic void rotate_vec(input longint x0, input longint y0, input bit [31:0] z0,
                                      output longint xo, output longint yo);
      longint x, y, tx, ty, zz;
      bit [31:0] z;
      x = (x0 * GAIN_INV + 8192) >>> 14;
      y = (y0 * GAIN_INV + 8192) >>> 14;
      z = z0;
      // fold the left half plane onto the right one
      if (((z + 32'h4000_0000) & 32'h8000_0000) != 0) begin
         x = -x;
         y = -y;
         z = z + 32'h8000_0000;
      end
      zz = longint'($signed(z));
      for (int i = 0; i < NSTEPS; i++) begin
         tx = x >>> i;
         ty = y >>> i;
         if (zz >= 0) begin
            x -= ty; y += tx; zz -= ARCTAN_TAB[i];
         end else begin
            x += ty; y -= tx; zz += ARCTAN_TAB[i];
         end
      end
      xo = x;
      yo = y;
   endfunction

   function automatic beam_result_type correct_beam(input logic [23:0] rng,
                                                    input logic [15:0] ang,
                                                    input logic inf, input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [15:0] hdg);
      beam_result_type res;
      longint bx, by, ox, oy, x, y, tx, ty;
      bit [31:0] z;
      bit [15:0] a;
      bit [63:0] mag, scaled;
      if (inf) begin
         res.range = rng; res.angle = ang; res.corrected = 1'b0;
         return res;
      end
      a = ang + hdg - ref_hdg_shadow;
      rotate_vec(longint'(rng), 0, {a, 16'h0}, bx, by);
      a = 16'h0 - ref_hdg_shadow;
      rotate_vec(longint'($signed(px)) - longint'($signed(ref_x_shadow)),
                 longint'($signed(py)) - longint'($signed(ref_y_shadow)), {a, 16'h0}, ox, oy);
      // vectoring cordic back to polar
      x = bx + ox;
      y = by + oy;
      z = '0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < NSTEPS; i++) begin
         tx = x >>> i;
         ty = y >>> i;
         if (y > 0) begin
            x += ty; y -= tx; z += 32'(ARCTAN_TAB[i]);
         end else begin
            x -= ty; y += tx; z -= 32'(ARCTAN_TAB[i]);
         end
      end
      mag = 64'(x);
      scaled = (mag * 64'(GAIN_INV) + (64'd1 << 29)) >> 30;
      res.range = (scaled > 64'hFF_FFFF) ? 24'hFF_FFFF : scaled[23:0];
      z = z + 32'h8000;
      res.angle = z[31:16];
      res.corrected = 1'b1;
      return res;
   endfunction

   // one beam transaction: hold start until the unit takes it
   task automatic send_beam(input logic [23:0] rng, input logic [15:0] ang, input logic inf,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] hdg);
      start <= 1'b1;
      req_beam_range <= rng;
      req_beam_angle <= ang;
      req_range_infinite <= inf;
      req_pose_x <= px;
      req_pose_y <= py;
      req_pose_heading <= hdg;
      do @(posedge clock); while (busy);
      pending_beams.push_back(correct_beam(rng, ang, inf, px, py, hdg));
   endtask

   task automatic pause_sender(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop feeding until every outstanding transaction has returned
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_beams.size() != 0) @(posedge clock);
   endtask

   // one write, then write enable is dropped before the next write so back to back writes never collide
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_REF_POS_X:   ref_x_shadow = data;
         CSR_REF_POS_Y:   ref_y_shadow = data;
         CSR_REF_HEADING: ref_hdg_shadow = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_reference(input logic [31:0] x, input logic [31:0] y,
                                input logic [15:0] hdg);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      write_csr(CSR_REF_POS_X, x);
      write_csr(CSR_REF_POS_Y, y);
      write_csr(CSR_REF_HEADING, {16'h0, hdg});
   endtask

   function automatic logic [31:0] near_pose(input logic [31:0] centre);
      logic [31:0] off;
      off = $urandom_range(0, 32'h7F_FFFF);
      return ($urandom_range(0, 1) != 0) ? centre + off : centre - off;
   endfunction

   // field extremes, infinite passthrough, origin, saturation
   task automatic test_directed();
      send_beam(24'h0, 16'h0, 1'b0, 32'h0, 32'h0, 16'h0);          // point at origin
      send_beam(24'hFF_FFFF, 16'h7FFF, 1'b0, 32'h0, 32'h0, 16'h0);
      send_beam(24'hFF_FFFF, 16'h8000, 1'b0, 32'h0, 32'h0, 16'h8000);
      send_beam(24'h12_3456, 16'h4000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
      send_beam(24'hFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
      send_beam(24'h1000, 16'hC000, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0);    // saturate
      send_beam(24'h1000, 16'h2000, 1'b0, 32'h8000_0000, 32'h8000_0000, 16'h4000);
      send_beam(24'h1, 16'h0001, 1'b0, 32'hFFFF_FFFF, 32'h1, 16'hC000);
      send_beam(24'h80_0000, 16'h4000, 1'b0, 32'hFF80_0000, 32'h0, 16'hC000);
      send_beam(24'h0, 16'h1234, 1'b0, 32'h10_0000, 32'hFFF0_0000, 16'h0);
      pause_sender(3);
      send_beam(24'h7F_FFFF, 16'hA000, 1'b0, 32'h0, 32'h7F_FFFF, 16'h6000);
   endtask

   // reference pose at extremes, plus a write to the unmapped index
   task automatic test_reference_extremes();
      set_reference(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      send_beam(24'hFF_FFFF, 16'h0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
      send_beam(24'h0, 16'h0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);     // origin again
      send_beam(24'h5000, 16'h8000, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
      set_reference(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
      send_beam(24'h2000, 16'h4000, 1'b0, 32'h8000_0100, 32'h7FFF_F000, 16'h8000);
      send_beam(24'hAB_CDEF, 16'h5555, 1'b1, 32'h0, 32'h0, 16'h0);
      send_beam(24'h0, 16'h0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1234);
   endtask

   // random beams over several reference poses; most poses sit near the reference
   task automatic test_random_beams();
      logic [31:0] px, py;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 500 == 0) begin
            case (n / 500)
               0: set_reference('0, '0, '0);
               1: set_reference($urandom, $urandom, 16'($urandom));
               2: set_reference(32'hFFFF_FFFF, 32'h1, 16'hFFFF);
               default: set_reference($urandom, $urandom, 16'($urandom));
            endcase
         end
         if (n == RAND_ITEMS / 3) wait_drained();
         if ($urandom_range(0, 3) == 0) begin
            px = $urandom;
            py = $urandom;
         end else begin
            px = near_pose(ref_x_shadow);
            py = near_pose(ref_y_shadow);
         end
         send_beam(24'($urandom_range(0, 24'hFF_FFFF)), 16'($urandom),
                   $urandom_range(0, 7) == 0, px, py, 16'($urandom));
         if (n < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0 && (n / 50) % 4 != 3)
            pause_sender($urandom_range(1, 12));
      end
   endtask

   // result checker: every rsp_valid transaction against the oldest prediction
   always @(posedge clock) begin
      beam_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_beams.size() == 0) begin
            $display("%0t: unexpected result range=%h angle=%h corrected=%b", $time,
                     rsp_fixed_range, rsp_fixed_angle, rsp_was_corrected);
            error_count++;
         end else begin
            want = pending_beams.pop_front();
            if (rsp_fixed_range !== want.range) begin
               $display("%0t: range expected %h actual %h", $time, want.range, rsp_fixed_range);
               error_count++;
            end
            if (rsp_fixed_angle !== want.angle) begin
               $display("%0t: angle expected %h actual %h", $time, want.angle, rsp_fixed_angle);
               error_count++;
            end
            if (rsp_was_corrected !== want.corrected) begin
               $display("%0t: corrected expected %b actual %b", $time, want.corrected,
                        rsp_was_corrected);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_reference_extremes();
      test_random_beams();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_beams.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
